// ===== hw/rtl/rwcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rwcs_pkg
// Shared constants, codes and types for the raycast wall column span block.
// ----------------------------------------------------------------------------
package rwcs_pkg;

    // defaults for the top-level parameters
    localparam int SCREEN_HEIGHT_DEF = 512;
    localparam int ANGLE_BITS_DEF    = 12;

    // field widths
    localparam int COLUMN_W  = 10;
    localparam int DIST_W    = 24;
    localparam int HEAD_W    = 12;
    localparam int ROW_W     = 10;
    localparam int COLOR_W   = 24;
    localparam int SCALE_W   = 32;
    localparam int CORR_W    = 24;
    localparam int DIVISOR_W = CORR_W + 1;
    localparam int COS_W     = 15;
    localparam int PHASE_W   = 16;
    localparam int CFG_IDX_W = 3;

    // cosine polynomial, Q14
    localparam logic [14:0] COS_A   = 15'd25736;
    localparam logic [13:0] COS_B   = 14'd10512;
    localparam logic [10:0] COS_C   = 11'd1160;
    localparam logic [14:0] ONE_Q14 = 15'd16384;

    // phase range where cosine is zero or negative
    localparam logic [PHASE_W-1:0] PHASE_Q1 = 16'h4000;
    localparam logic [PHASE_W-1:0] PHASE_Q3 = 16'hC000;

    // register reset values
    localparam logic [SCALE_W-1:0] SCALE_RST       = 32'd4843140;
    localparam logic [COLOR_W-1:0] COLOR_WEST_RST  = 24'h808080;
    localparam logic [COLOR_W-1:0] COLOR_EAST_RST  = 24'hFFFF00;
    localparam logic [COLOR_W-1:0] COLOR_SOUTH_RST = 24'h00FF00;
    localparam logic [COLOR_W-1:0] COLOR_NORTH_RST = 24'hFF0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROJ_SCALE  = 3'd0,
        CFG_COLOR_WEST  = 3'd1,
        CFG_COLOR_EAST  = 3'd2,
        CFG_COLOR_SOUTH = 3'd3,
        CFG_COLOR_NORTH = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        FACE_WEST  = 2'd0,
        FACE_EAST  = 2'd1,
        FACE_SOUTH = 2'd2,
        FACE_NORTH = 2'd3
    } facing_t;

    // fields that ride along the pipeline untouched
    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        facing_t             facing;
    } span_side_t;

endpackage

// ===== hw/rtl/raycast_wall_column_span.sv =====
// ----------------------------------------------------------------------------
// raycast_wall_column_span
// One ray hit per screen column in, one clamped wall span with color out.
// ----------------------------------------------------------------------------
// Input stream (s_*): one transaction per column carries the column, raw hit
// distance, ray and player headings in tdata and the grid side in tuser.
// Output stream (m_*): one transaction per input, in order, with column, top
// row, bottom row and color in tdata and the face code in tuser.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index in the same
// cycle (projection scale, then west/east/south/north colors). The user must
// write only while no transaction is in flight; the block does not check.
// Pipeline: six cosine/correction stages, the divider's range-check stage
// plus one stage per quotient bit, and the output register.
// Throughput: one transaction per clock while m_tready stays high; every
// stage holds a valid bit and loads when it is empty or its successor loads,
// so a stalled receiver fills the empty stages before s_tready drops.
// Nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register defaults.
// ----------------------------------------------------------------------------
module raycast_wall_column_span #(
    parameter int SCREEN_HEIGHT = rwcs_pkg::SCREEN_HEIGHT_DEF,
    parameter int ANGLE_BITS    = rwcs_pkg::ANGLE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // tdata: column[9:0], hit_distance[33:10], ray_heading[45:34],
    //        player_heading[57:46], zero pad[63:58]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,
    // tuser: side_flag[0]
    input  logic [0:0]                       s_tuser,
    // tdata: column_out[9:0], wall_top[19:10], wall_bottom[29:20],
    //        wall_color[53:30], zero pad[55:54]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [55:0]                      m_tdata,
    // tuser: facing[1:0]
    output logic [1:0]                       m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [rwcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwcs_pkg::SCALE_W-1:0]     cfg_wdata
);

    localparam int QW = $clog2(SCREEN_HEIGHT + 1);
    localparam logic [QW-1:0] MID_ROW = QW'(SCREEN_HEIGHT / 2);
    localparam logic [QW-1:0] LOW_ROW = QW'(SCREEN_HEIGHT - SCREEN_HEIGHT / 2);
    localparam logic [QW-1:0] H_ROW   = QW'(SCREEN_HEIGHT);
    localparam int CLW = rwcs_pkg::COLOR_W;
    localparam int RWW = rwcs_pkg::ROW_W;

    // configuration registers
    logic [rwcs_pkg::SCALE_W-1:0] scale_reg;
    logic [CLW-1:0] color_west_reg, color_east_reg, color_south_reg, color_north_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg       <= rwcs_pkg::SCALE_RST;
            color_west_reg  <= rwcs_pkg::COLOR_WEST_RST;
            color_east_reg  <= rwcs_pkg::COLOR_EAST_RST;
            color_south_reg <= rwcs_pkg::COLOR_SOUTH_RST;
            color_north_reg <= rwcs_pkg::COLOR_NORTH_RST;
        end else if (cfg_wr_en) begin
            unique case (rwcs_pkg::cfg_index_t'(cfg_index))
                rwcs_pkg::CFG_PROJ_SCALE:  scale_reg       <= cfg_wdata;
                rwcs_pkg::CFG_COLOR_WEST:  color_west_reg  <= cfg_wdata[CLW-1:0];
                rwcs_pkg::CFG_COLOR_EAST:  color_east_reg  <= cfg_wdata[CLW-1:0];
                rwcs_pkg::CFG_COLOR_SOUTH: color_south_reg <= cfg_wdata[CLW-1:0];
                rwcs_pkg::CFG_COLOR_NORTH: color_north_reg <= cfg_wdata[CLW-1:0];
                default: ;
            endcase
        end
    end

    // front end: fish-eye correction
    logic                         cc_valid, cc_ready;
    rwcs_pkg::span_side_t         cc_side;
    logic [rwcs_pkg::CORR_W-1:0]  cc_corr;

    rwcs_cos_corr #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cos_corr (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_column    (s_tdata[9:0]),
        .in_dist      (s_tdata[33:10]),
        .in_ray       (s_tdata[45:34]),
        .in_player    (s_tdata[57:46]),
        .in_side_flag (s_tuser[0]),
        .out_valid    (cc_valid),
        .out_ready    (cc_ready),
        .out_side     (cc_side),
        .out_corr     (cc_corr)
    );

    // half height
    logic                  dv_valid, dv_ready;
    rwcs_pkg::span_side_t  dv_side;
    logic [QW-1:0]         dv_half;
    logic                  dv_full;

    rwcs_divider #(
        .QW (QW)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cc_valid),
        .in_ready  (cc_ready),
        .in_side   (cc_side),
        .in_corr   (cc_corr),
        .scale     (scale_reg),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_side  (dv_side),
        .out_half  (dv_half),
        .out_full  (dv_full)
    );

    // output register: clamp and color select
    logic                        m_tvalid_reg;
    logic [rwcs_pkg::COLUMN_W-1:0] column_reg;
    logic [RWW-1:0]              top_reg, bottom_reg;
    logic [CLW-1:0]              color_reg, color_next;
    rwcs_pkg::facing_t           facing_reg;
    logic [QW-1:0]               top_next, bottom_next;

    always_comb begin
        top_next    = (dv_full || dv_half >= MID_ROW) ? '0 : MID_ROW - dv_half;
        bottom_next = (dv_full || dv_half >= LOW_ROW) ? H_ROW : MID_ROW + dv_half;
        case (dv_side.facing)
            rwcs_pkg::FACE_WEST:  color_next = color_west_reg;
            rwcs_pkg::FACE_EAST:  color_next = color_east_reg;
            rwcs_pkg::FACE_SOUTH: color_next = color_south_reg;
            default:              color_next = color_north_reg;
        endcase
    end

    assign dv_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (dv_ready) begin
            m_tvalid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (dv_ready) begin
            column_reg <= dv_side.column;
            top_reg    <= RWW'(top_next);
            bottom_reg <= RWW'(bottom_next);
            color_reg  <= color_next;
            facing_reg <= dv_side.facing;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, color_reg, bottom_reg, top_reg, column_reg};
    assign m_tuser  = facing_reg;

endmodule

// ===== hw/rtl/rwcs_cos_corr.sv =====
// ----------------------------------------------------------------------------
// rwcs_cos_corr
// Fish-eye correction: angle difference, polynomial cosine and distance
// multiply in six register stages, one multiplier in each of stages 2 to 6.
// ----------------------------------------------------------------------------
module rwcs_cos_corr #(
    parameter int ANGLE_BITS = rwcs_pkg::ANGLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rwcs_pkg::COLUMN_W-1:0]   in_column,
    input  logic [rwcs_pkg::DIST_W-1:0]     in_dist,
    input  logic [rwcs_pkg::HEAD_W-1:0]     in_ray,
    input  logic [rwcs_pkg::HEAD_W-1:0]     in_player,
    input  logic                            in_side_flag,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rwcs_pkg::span_side_t            out_side,
    output logic [rwcs_pkg::CORR_W-1:0]     out_corr
);

    localparam int PW = rwcs_pkg::PHASE_W;
    localparam int CW = rwcs_pkg::COS_W;
    localparam int DW = rwcs_pkg::DIST_W;
    localparam logic [ANGLE_BITS-1:0] QTR  = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(2) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] QTR3 = ANGLE_BITS'(3) << (ANGLE_BITS - 2);

    // stage valids and ready chain
    logic st1_vld_reg, st2_vld_reg, st3_vld_reg, st4_vld_reg, st5_vld_reg, st6_vld_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    // stage 1: angle fold
    logic [ANGLE_BITS-1:0]     ray_a, ply_a, diff;
    logic [PW-1:0]             phase, fold, s_full;
    logic                      zero_next;
    logic [CW-1:0]             s_next;
    rwcs_pkg::span_side_t      side_next;
    rwcs_pkg::span_side_t      st1_side_reg;
    logic [DW-1:0]             st1_dist_reg;
    logic                      st1_zero_reg;
    logic [CW-1:0]             st1_s_reg;

    // stage 2: s^2
    logic [2*CW-1:0]           sq_prod;
    rwcs_pkg::span_side_t      st2_side_reg;
    logic [DW-1:0]             st2_dist_reg;
    logic                      st2_zero_reg;
    logic [CW-1:0]             st2_s_reg;
    logic [CW-1:0]             st2_sq_reg;

    // stage 3: t1 = B - C*s2
    logic [25:0]               c_prod;
    logic [13:0]               t1_next;
    rwcs_pkg::span_side_t      st3_side_reg;
    logic [DW-1:0]             st3_dist_reg;
    logic                      st3_zero_reg;
    logic [CW-1:0]             st3_s_reg;
    logic [CW-1:0]             st3_sq_reg;
    logic [13:0]               st3_t1_reg;

    // stage 4: t2 = A - t1*s2
    logic [28:0]               t1_prod;
    logic [CW-1:0]             t2_next;
    rwcs_pkg::span_side_t      st4_side_reg;
    logic [DW-1:0]             st4_dist_reg;
    logic                      st4_zero_reg;
    logic [CW-1:0]             st4_s_reg;
    logic [CW-1:0]             st4_t2_reg;

    // stage 5: cos = s*t2, clamped
    logic [2*CW-1:0]           cos_prod;
    logic [CW:0]               cos_raw;
    logic [CW-1:0]             cos_next;
    rwcs_pkg::span_side_t      st5_side_reg;
    logic [DW-1:0]             st5_dist_reg;
    logic [CW-1:0]             st5_cos_reg;

    // stage 6: corrected distance
    logic [DW+CW-1:0]          corr_prod;
    rwcs_pkg::span_side_t      st6_side_reg;
    logic [rwcs_pkg::CORR_W-1:0] st6_corr_reg;

    assign rdy6     = !st6_vld_reg || out_ready;
    assign rdy5     = !st5_vld_reg || rdy6;
    assign rdy4     = !st4_vld_reg || rdy5;
    assign rdy3     = !st3_vld_reg || rdy4;
    assign rdy2     = !st2_vld_reg || rdy3;
    assign rdy1     = !st1_vld_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        ray_a  = ANGLE_BITS'(in_ray);
        ply_a  = ANGLE_BITS'(in_player);
        diff   = ray_a - ply_a;
        phase  = PW'(diff) << (PW - ANGLE_BITS);
        // quarter turn or more away: cosine not positive
        zero_next = (phase >= rwcs_pkg::PHASE_Q1) && (phase <= rwcs_pkg::PHASE_Q3);
        fold   = phase[PW-1] ? (PW'(0) - phase) : phase;
        s_full = PW'(rwcs_pkg::ONE_Q14) - fold;
        s_next = s_full[CW-1:0];
        side_next.column = in_column;
        if (!in_side_flag) begin
            side_next.facing = (ray_a >= QTR && ray_a <= QTR3) ?
                               rwcs_pkg::FACE_WEST : rwcs_pkg::FACE_EAST;
        end else begin
            side_next.facing = (ray_a <= HALF) ? rwcs_pkg::FACE_SOUTH : rwcs_pkg::FACE_NORTH;
        end
    end

    always_comb begin
        sq_prod   = st1_s_reg * st1_s_reg;
        c_prod    = rwcs_pkg::COS_C * st2_sq_reg;
        t1_next   = rwcs_pkg::COS_B - c_prod[25:14];
        t1_prod   = st3_t1_reg * st3_sq_reg;
        t2_next   = rwcs_pkg::COS_A - t1_prod[28:14];
        cos_prod  = st4_s_reg * st4_t2_reg;
        cos_raw   = cos_prod[2*CW-1:14];
        if (st4_zero_reg) begin
            cos_next = '0;
        end else if (cos_raw > (CW+1)'(rwcs_pkg::ONE_Q14)) begin
            cos_next = rwcs_pkg::ONE_Q14;
        end else begin
            cos_next = cos_raw[CW-1:0];
        end
        corr_prod = st5_dist_reg * st5_cos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
            st3_vld_reg <= 1'b0;
            st4_vld_reg <= 1'b0;
            st5_vld_reg <= 1'b0;
            st6_vld_reg <= 1'b0;
        end else begin
            if (rdy1) st1_vld_reg <= in_valid;
            if (rdy2) st2_vld_reg <= st1_vld_reg;
            if (rdy3) st3_vld_reg <= st2_vld_reg;
            if (rdy4) st4_vld_reg <= st3_vld_reg;
            if (rdy5) st5_vld_reg <= st4_vld_reg;
            if (rdy6) st6_vld_reg <= st5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            st1_side_reg <= side_next;
            st1_dist_reg <= in_dist;
            st1_zero_reg <= zero_next;
            st1_s_reg    <= s_next;
        end
        if (rdy2) begin
            st2_side_reg <= st1_side_reg;
            st2_dist_reg <= st1_dist_reg;
            st2_zero_reg <= st1_zero_reg;
            st2_s_reg    <= st1_s_reg;
            st2_sq_reg   <= sq_prod[28:14];
        end
        if (rdy3) begin
            st3_side_reg <= st2_side_reg;
            st3_dist_reg <= st2_dist_reg;
            st3_zero_reg <= st2_zero_reg;
            st3_s_reg    <= st2_s_reg;
            st3_sq_reg   <= st2_sq_reg;
            st3_t1_reg   <= t1_next;
        end
        if (rdy4) begin
            st4_side_reg <= st3_side_reg;
            st4_dist_reg <= st3_dist_reg;
            st4_zero_reg <= st3_zero_reg;
            st4_s_reg    <= st3_s_reg;
            st4_t2_reg   <= t2_next;
        end
        if (rdy5) begin
            st5_side_reg <= st4_side_reg;
            st5_dist_reg <= st4_dist_reg;
            st5_cos_reg  <= cos_next;
        end
        if (rdy6) begin
            st6_side_reg <= st5_side_reg;
            // product stays below 2^38
            st6_corr_reg <= corr_prod[37:14];
        end
    end

    assign out_valid = st6_vld_reg;
    assign out_side  = st6_side_reg;
    assign out_corr  = st6_corr_reg;

endmodule

// ===== hw/rtl/rwcs_div_stage.sv =====
// ----------------------------------------------------------------------------
// rwcs_div_stage
// One restoring-division stage: resolves quotient bit BIT.
// ----------------------------------------------------------------------------
module rwcs_div_stage #(
    parameter int QW  = 10,
    parameter int BIT = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rwcs_pkg::span_side_t              in_side,
    input  logic [rwcs_pkg::SCALE_W-1:0]      in_rem,
    input  logic [rwcs_pkg::DIVISOR_W-1:0]    in_divisor,
    input  logic [QW-1:0]                     in_quot,
    input  logic                              in_full,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rwcs_pkg::span_side_t              out_side,
    output logic [rwcs_pkg::SCALE_W-1:0]      out_rem,
    output logic [rwcs_pkg::DIVISOR_W-1:0]    out_divisor,
    output logic [QW-1:0]                     out_quot,
    output logic                              out_full
);

    localparam int RW   = rwcs_pkg::SCALE_W;
    localparam int EXTW = (rwcs_pkg::DIVISOR_W + QW > RW) ? rwcs_pkg::DIVISOR_W + QW : RW;

    logic                         vld_reg;
    rwcs_pkg::span_side_t         side_reg;
    logic [RW-1:0]                rem_reg, rem_next;
    logic [rwcs_pkg::DIVISOR_W-1:0] divisor_reg;
    logic [QW-1:0]                quot_reg, quot_next;
    logic                         full_reg;
    logic [EXTW-1:0]              shifted, rem_ext;
    logic                         fits;

    assign in_ready = !vld_reg || out_ready;

    always_comb begin
        shifted   = EXTW'(in_divisor) << BIT;
        rem_ext   = EXTW'(in_rem);
        fits      = rem_ext >= shifted;
        rem_next  = fits ? RW'(rem_ext - shifted) : in_rem;
        quot_next = in_quot;
        quot_next[BIT] = fits;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            side_reg    <= in_side;
            rem_reg     <= rem_next;
            divisor_reg <= in_divisor;
            quot_reg    <= quot_next;
            full_reg    <= in_full;
        end
    end

    assign out_valid   = vld_reg;
    assign out_side    = side_reg;
    assign out_rem     = rem_reg;
    assign out_divisor = divisor_reg;
    assign out_quot    = quot_reg;
    assign out_full    = full_reg;

endmodule

// ===== hw/rtl/rwcs_divider.sv =====
// ----------------------------------------------------------------------------
// rwcs_divider
// Pipelined half-height divider: scale / (2 * corr), one quotient bit per
// stage. Quotients that reach 2^QW, and a zero divisor, flag a full wall.
// ----------------------------------------------------------------------------
module rwcs_divider #(
    parameter int QW = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rwcs_pkg::span_side_t            in_side,
    input  logic [rwcs_pkg::CORR_W-1:0]     in_corr,
    input  logic [rwcs_pkg::SCALE_W-1:0]    scale,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rwcs_pkg::span_side_t            out_side,
    output logic [QW-1:0]                   out_half,
    output logic                            out_full
);

    localparam int RW = rwcs_pkg::SCALE_W;
    localparam int DV = rwcs_pkg::DIVISOR_W;

    logic                  vld_w  [QW+1];
    logic                  rdy_w  [QW+1];
    rwcs_pkg::span_side_t  side_w [QW+1];
    logic [RW-1:0]         rem_w  [QW+1];
    logic [DV-1:0]         dvs_w  [QW+1];
    logic [QW-1:0]         quot_w [QW+1];
    logic                  full_w [QW+1];

    // entry stage: divisor and range check
    logic                  vld_reg;
    rwcs_pkg::span_side_t  side_reg;
    logic [RW-1:0]         rem_reg;
    logic [DV-1:0]         dvs_reg, dvs_next;
    logic                  full_reg, full_next;

    always_comb begin
        dvs_next  = {in_corr, 1'b0};
        // quotient >= 2^QW  <=>  floor(scale / 2^QW) >= divisor
        full_next = (in_corr == '0) || ((scale >> QW) >= RW'(dvs_next));
    end

    assign in_ready = !vld_reg || rdy_w[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            side_reg <= in_side;
            rem_reg  <= scale;
            dvs_reg  <= dvs_next;
            full_reg <= full_next;
        end
    end

    assign vld_w[0]  = vld_reg;
    assign side_w[0] = side_reg;
    assign rem_w[0]  = rem_reg;
    assign dvs_w[0]  = dvs_reg;
    assign quot_w[0] = '0;
    assign full_w[0] = full_reg;

    for (genvar k = 0; k < QW; k++) begin : g_bit
        rwcs_div_stage #(
            .QW  (QW),
            .BIT (QW - 1 - k)
        ) u_stage (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .in_valid    (vld_w[k]),
            .in_ready    (rdy_w[k]),
            .in_side     (side_w[k]),
            .in_rem      (rem_w[k]),
            .in_divisor  (dvs_w[k]),
            .in_quot     (quot_w[k]),
            .in_full     (full_w[k]),
            .out_valid   (vld_w[k+1]),
            .out_ready   (rdy_w[k+1]),
            .out_side    (side_w[k+1]),
            .out_rem     (rem_w[k+1]),
            .out_divisor (dvs_w[k+1]),
            .out_quot    (quot_w[k+1]),
            .out_full    (full_w[k+1])
        );
    end

    assign rdy_w[QW] = out_ready;
    assign out_valid = vld_w[QW];
    assign out_side  = side_w[QW];
    assign out_half  = quot_w[QW];
    assign out_full  = full_w[QW];

endmodule

// ===== tb/raycast_wall_column_span_test.sv =====
// ----------------------------------------------------------------------------
// raycast_wall_column_span_test
// Self-checking testbench for the raycast wall column span block.
// ----------------------------------------------------------------------------
// Ray hits go in on the s_ stream. Each accepted hit is run through a local
// model of the fish-eye correction, wall height division and face selection,
// and the span it predicts is queued. Every span taken from the m_ stream is
// checked field by field against the oldest queued span. Both sides idle at
// random. One test holds the receiver off long enough to back the pipeline
// up into the input. Register writes happen only while the block is empty.
// ----------------------------------------------------------------------------
module raycast_wall_column_span_test;

    localparam int SCREEN_H = rwcs_pkg::SCREEN_HEIGHT_DEF;
    localparam int ANGLE_W  = rwcs_pkg::ANGLE_BITS_DEF;
    localparam int LATENCY  = 8 + $clog2(SCREEN_H + 1);
    localparam int TIMEOUT  = 2_000_000;

    typedef struct {
        bit [rwcs_pkg::COLUMN_W-1:0] column;
        bit [rwcs_pkg::DIST_W-1:0]   distance;
        bit [rwcs_pkg::HEAD_W-1:0]   ray;
        bit [rwcs_pkg::HEAD_W-1:0]   player;
        bit                          side;
    } ray_hit_t;

    typedef struct {
        bit [rwcs_pkg::COLUMN_W-1:0] column;
        bit [rwcs_pkg::ROW_W-1:0]    top;
        bit [rwcs_pkg::ROW_W-1:0]    bottom;
        bit [rwcs_pkg::COLOR_W-1:0]  color;
        rwcs_pkg::facing_t           facing;
    } wall_span_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [63:0]                    s_tdata   = '0;
    logic [0:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [55:0]                    m_tdata;
    logic [1:0]                     m_tuser;
    logic                           cfg_wr_en = 1'b0;
    logic [rwcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rwcs_pkg::SCALE_W-1:0]   cfg_wdata = '0;

    // register shadows used by the span model
    bit [rwcs_pkg::SCALE_W-1:0] scale_shadow;
    bit [rwcs_pkg::COLOR_W-1:0] color_shadow [4];

    wall_span_t expected_spans[$];
    wall_span_t got_span;
    wall_span_t want_span;
    int         fail_count   = 0;
    bit         src_steady   = 1'b0;
    bit         sink_steady  = 1'b0;
    int         hold_request = 0;
    bit         sink_holding = 1'b0;

    raycast_wall_column_span u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Q14 cosine of a 16 bit phase, zero where the true cosine is <= 0
    function automatic bit [rwcs_pkg::COS_W-1:0] cosine_q14(
        bit [rwcs_pkg::PHASE_W-1:0] phase);
        bit [31:0] fold;
        bit [31:0] s;
        bit [31:0] s2;
        bit [31:0] t1;
        bit [31:0] t2;
        bit [31:0] c;
        if (phase >= rwcs_pkg::PHASE_Q1 && phase <= rwcs_pkg::PHASE_Q3)
            return '0;
        fold = (phase < 16'h8000) ? 32'(phase) : 32'h10000 - 32'(phase);
        s  = 32'(rwcs_pkg::ONE_Q14) - fold;
        s2 = (s * s) >> 14;
        t1 = 32'(rwcs_pkg::COS_B) - ((32'(rwcs_pkg::COS_C) * s2) >> 14);
        t2 = 32'(rwcs_pkg::COS_A) - ((t1 * s2) >> 14);
        c  = (s * t2) >> 14;
        if (c > 32'(rwcs_pkg::ONE_Q14))
            c = 32'(rwcs_pkg::ONE_Q14);
        return c[rwcs_pkg::COS_W-1:0];
    endfunction

    function automatic wall_span_t predict_span(ray_hit_t hit);
        wall_span_t                 span;
        bit [ANGLE_W-1:0]           diff;
        bit [rwcs_pkg::PHASE_W-1:0] phase;
        bit [63:0]                  corrected;
        bit [63:0]                  half;
        bit [63:0]                  mid;
        int                         quarter;
        mid     = SCREEN_H / 2;
        quarter = 1 << (ANGLE_W - 2);
        diff    = hit.ray[ANGLE_W-1:0] - hit.player[ANGLE_W-1:0];
        phase   = rwcs_pkg::PHASE_W'(diff) << (rwcs_pkg::PHASE_W - ANGLE_W);
        corrected = (64'(hit.distance) * 64'(cosine_q14(phase))) >> 14;
        if (corrected == 0) begin
            span.top    = '0;
            span.bottom = rwcs_pkg::ROW_W'(SCREEN_H);
        end else begin
            half        = 64'(scale_shadow) / (2 * corrected);
            span.top    = (half >= mid) ? '0 : rwcs_pkg::ROW_W'(mid - half);
            span.bottom = (half >= SCREEN_H - mid) ? rwcs_pkg::ROW_W'(SCREEN_H) :
                          rwcs_pkg::ROW_W'(mid + half);
        end
        if (!hit.side)
            span.facing = (hit.ray >= quarter && hit.ray <= 3 * quarter) ?
                          rwcs_pkg::FACE_WEST : rwcs_pkg::FACE_EAST;
        else
            span.facing = (hit.ray <= 2 * quarter) ?
                          rwcs_pkg::FACE_SOUTH : rwcs_pkg::FACE_NORTH;
        span.color  = color_shadow[span.facing];
        span.column = hit.column;
        return span;
    endfunction

    function automatic ray_hit_t make_hit(int column, int distance, int ray, int player,
                                          bit side);
        ray_hit_t hit;
        hit.column   = rwcs_pkg::COLUMN_W'(column);
        hit.distance = rwcs_pkg::DIST_W'(distance);
        hit.ray      = rwcs_pkg::HEAD_W'(ray);
        hit.player   = rwcs_pkg::HEAD_W'(player);
        hit.side     = side;
        return hit;
    endfunction

    // mostly rays inside the view cone, some behind the player
    function automatic ray_hit_t random_hit();
        ray_hit_t hit;
        int       pick;
        hit.column = rwcs_pkg::COLUMN_W'($urandom_range(0, 1023));
        hit.player = rwcs_pkg::HEAD_W'($urandom_range(0, 4095));
        hit.side   = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 80)
            hit.ray = hit.player + rwcs_pkg::HEAD_W'($urandom_range(0, 2046))
                      - rwcs_pkg::HEAD_W'(1023);
        else
            hit.ray = rwcs_pkg::HEAD_W'($urandom_range(0, 4095));
        pick = $urandom_range(0, 99);
        if (pick < 4)
            hit.distance = '0;
        else if (pick < 30)
            hit.distance = rwcs_pkg::DIST_W'($urandom_range(1, 16'h3FFF));
        else if (pick < 75)
            hit.distance = rwcs_pkg::DIST_W'($urandom_range(16'h4000, 20'hFFFFF));
        else
            hit.distance = rwcs_pkg::DIST_W'($urandom);
        return hit;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called at a rising edge; returns at the edge where the hit is taken
    task automatic send_ray(ray_hit_t hit);
        int gap;
        gap = src_steady ? 0 : idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, hit.player, hit.ray, hit.distance, hit.column};
        s_tuser  <= hit.side;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_spans.push_back(predict_span(hit));
    endtask

    // wait until every queued span has come out and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_spans.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_reg(rwcs_pkg::cfg_index_t idx, bit [rwcs_pkg::SCALE_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            rwcs_pkg::CFG_PROJ_SCALE:
                scale_shadow = value;
            rwcs_pkg::CFG_COLOR_WEST:
                color_shadow[rwcs_pkg::FACE_WEST]  = value[rwcs_pkg::COLOR_W-1:0];
            rwcs_pkg::CFG_COLOR_EAST:
                color_shadow[rwcs_pkg::FACE_EAST]  = value[rwcs_pkg::COLOR_W-1:0];
            rwcs_pkg::CFG_COLOR_SOUTH:
                color_shadow[rwcs_pkg::FACE_SOUTH] = value[rwcs_pkg::COLOR_W-1:0];
            rwcs_pkg::CFG_COLOR_NORTH:
                color_shadow[rwcs_pkg::FACE_NORTH] = value[rwcs_pkg::COLOR_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic write_colors(bit [rwcs_pkg::COLOR_W-1:0] west,
                                bit [rwcs_pkg::COLOR_W-1:0] east,
                                bit [rwcs_pkg::COLOR_W-1:0] south,
                                bit [rwcs_pkg::COLOR_W-1:0] north);
        write_reg(rwcs_pkg::CFG_COLOR_WEST, 32'(west));
        write_reg(rwcs_pkg::CFG_COLOR_EAST, 32'(east));
        write_reg(rwcs_pkg::CFG_COLOR_SOUTH, 32'(south));
        write_reg(rwcs_pkg::CFG_COLOR_NORTH, 32'(north));
    endtask

    task automatic send_random(int count);
        repeat (count) send_ray(random_hit());
    endtask

    // reset register values, field extremes, angle and facing boundaries
    task automatic test_directed_spans();
        send_ray(make_hit(0, 0, 0, 0, 1'b0));                // zero distance
        send_ray(make_hit(1023, 24'hFFFFFF, 4095, 4095, 1'b1));
        send_ray(make_hit(512, 24'h000100, 1024, 1024, 1'b0)); // tall wall
        send_ray(make_hit(3, 9459, 2000, 2000, 1'b0));        // half height just 256
        send_ray(make_hit(4, 9460, 2000, 2000, 1'b0));        // half height 255
        send_ray(make_hit(5, 24'h004000, 100, 100, 1'b1));
        // west/east and south/north boundaries on the ray heading
        send_ray(make_hit(10, 24'h008000, 1023, 1023, 1'b0));
        send_ray(make_hit(11, 24'h008000, 3072, 3072, 1'b0));
        send_ray(make_hit(12, 24'h008000, 3073, 3073, 1'b0));
        send_ray(make_hit(13, 24'h008000, 2048, 2048, 1'b1));
        send_ray(make_hit(14, 24'h008000, 2049, 2049, 1'b1));
        send_ray(make_hit(15, 24'h008000, 0, 0, 1'b1));
        send_ray(make_hit(16, 24'h008000, 4095, 4095, 1'b0));
        // angle difference around a quarter turn either way
        send_ray(make_hit(20, 24'h020000, 1024, 0, 1'b0));
        send_ray(make_hit(21, 24'h020000, 1023, 0, 1'b0));
        send_ray(make_hit(22, 24'h020000, 0, 1024, 1'b1));
        send_ray(make_hit(23, 24'h020000, 3073, 0, 1'b1));
        send_ray(make_hit(24, 24'h020000, 2048, 0, 1'b0));    // straight behind
        send_ray(make_hit(25, 1, 1000, 0, 1'b0));             // truncates to zero
        send_ray(make_hit(26, 24'h003000, 10, 4090, 1'b1));   // heading wrap
        send_ray(make_hit(27, 24'hAAAAAA, 12'h555, 12'hAAA, 1'b1));
        send_ray(make_hit(28, 24'h555555, 12'hAAA, 12'h555, 1'b0));
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(rwcs_pkg::CFG_PROJ_SCALE, '0);
        write_colors('0, 24'hFFFFFF, '0, 24'hFFFFFF);
        send_random(20);
        drain();
        write_reg(rwcs_pkg::CFG_PROJ_SCALE, '1);
        write_colors(24'hFFFFFF, '0, 24'hFFFFFF, '0);
        send_random(20);
        drain();
    endtask

    task automatic test_random_phases();
        for (int phase_n = 0; phase_n < 5; phase_n++) begin
            src_steady  = (phase_n == 2);
            sink_steady = (phase_n == 2) || (phase_n == 4);
            if ($urandom_range(0, 3) == 0)
                write_reg(rwcs_pkg::CFG_PROJ_SCALE, $urandom);
            else
                write_reg(rwcs_pkg::CFG_PROJ_SCALE,
                          $urandom_range(32'h0004_0000, 32'h0100_0000));
            write_colors(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
            send_random(105);
            drain();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // receiver stops long enough for the pipeline to fill and stall the input
    task automatic test_output_backpressure();
        hold_request = 4 * LATENCY + 40;
        while (!sink_holding) @(posedge aclk);
        src_steady = 1'b1;
        send_random(60);
        src_steady = 1'b0;
        drain();
    endtask

    initial begin : result_sink
        int wait_n;
        forever begin
            if (hold_request > 0) begin
                wait_n       = hold_request;
                hold_request = 0;
                sink_holding = 1'b1;
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
                sink_holding = 1'b0;
            end else begin
                wait_n = sink_steady ? 0 : idle_gap();
                if (wait_n > 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_n) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_span.column = m_tdata[9:0];
            got_span.top    = m_tdata[19:10];
            got_span.bottom = m_tdata[29:20];
            got_span.color  = m_tdata[53:30];
            got_span.facing = rwcs_pkg::facing_t'(m_tuser);
            if (expected_spans.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected span: column %0d top %0d bottom %0d",
                             got_span.column, got_span.top, got_span.bottom);
                fail_count++;
            end else begin
                want_span = expected_spans.pop_front();
                if (got_span.column != want_span.column || got_span.top != want_span.top
                    || got_span.bottom != want_span.bottom
                    || got_span.color != want_span.color
                    || got_span.facing != want_span.facing) begin
                    if (fail_count < 10) begin
                        $display({"span mismatch: expected column %0d top %0d",
                                  " bottom %0d color %06h facing %s"},
                                 want_span.column, want_span.top, want_span.bottom,
                                 want_span.color, want_span.facing.name());
                        $display({"                 actual column %0d top %0d",
                                  " bottom %0d color %06h facing %s"},
                                 got_span.column, got_span.top, got_span.bottom,
                                 got_span.color, got_span.facing.name());
                    end
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT);
        $display("raycast_wall_column_span regression: fail");
        $finish;
    end

    initial begin
        scale_shadow                       = rwcs_pkg::SCALE_RST;
        color_shadow[rwcs_pkg::FACE_WEST]  = rwcs_pkg::COLOR_WEST_RST;
        color_shadow[rwcs_pkg::FACE_EAST]  = rwcs_pkg::COLOR_EAST_RST;
        color_shadow[rwcs_pkg::FACE_SOUTH] = rwcs_pkg::COLOR_SOUTH_RST;
        color_shadow[rwcs_pkg::FACE_NORTH] = rwcs_pkg::COLOR_NORTH_RST;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_spans();
        test_register_extremes();
        test_output_backpressure();
        test_random_phases();

        if (fail_count == 0 && expected_spans.size() == 0)
            $display("raycast_wall_column_span regression: pass");
        else
            $display("raycast_wall_column_span regression: fail");
        $finish;
    end

endmodule
